>>> rtl/core/cms_pkg.sv
// Package for the counted multiset table: command/result beat types,
// opcode and status codes. No dependencies.
package cms_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 32;
    localparam int INDEX_W = 6;
    localparam int DIST_W  = 7;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] index;
    } t_cms_in;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] count;
        logic [DIST_W-1:0]  distinct;
        logic [KEY_W-1:0]   read_key;
        logic [1:0]         status;
    } t_cms_out;

endpackage

>>> rtl/core/cms_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module cms_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/cms_ctrl.sv
// Sequencer for the counted multiset table: key scan, count update,
// shift-down on delete, indexed read. Uses cms_pkg; drives cms_ram ports.
module cms_ctrl #(
    parameter int ENTRIES = 64,
    parameter int KW      = 32,
    parameter int AW      = 6,
    parameter int UW      = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  cms_pkg::t_cms_in       i_cmd,
    output logic                   o_busy,
    output logic                   o_done,
    output cms_pkg::t_cms_out      o_result,
    output logic                   o_we,
    output logic [AW-1:0]          o_waddr,
    output logic [KW+31:0]         o_wdata,
    output logic                   o_re,
    output logic [AW-1:0]          o_raddr,
    input  logic [KW+31:0]         i_rdata
);
    import cms_pkg::*;

    localparam int PW = UW + 1;
    localparam int CW = (UW > INDEX_W) ? UW : INDEX_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN_RD = 3'd1;
    localparam logic [2:0] S_SCAN_CK = 3'd2;
    localparam logic [2:0] S_SH_RD   = 3'd3;
    localparam logic [2:0] S_SH_WR   = 3'd4;
    localparam logic [2:0] S_RD_WAIT = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [1:0]         r_op, n_op;
    logic [KW-1:0]      r_key, n_key;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [UW-1:0]      r_used, n_used;
    logic               r_done, n_done;
    t_cms_out           r_res, n_res;

    logic [KW-1:0]      rd_key;
    logic [COUNT_W-1:0] rd_cnt;
    logic [PW-1:0]      ptr_p1;
    logic [PW-1:0]      ptr_p2;
    logic [PW-1:0]      used_w;
    logic               do_nf;
    logic [1:0]         nf_op;
    logic [KW-1:0]      nf_key;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] cnt_dec;

    function automatic t_cms_out mk_res(input logic f, input logic [COUNT_W-1:0] c,
                                        input logic [UW-1:0] u,
                                        input logic [KEY_W-1:0] rk,
                                        input logic [1:0] st);
        t_cms_out r;
        r.found    = f;
        r.count    = c;
        r.distinct = DIST_W'(u);
        r.read_key = rk;
        r.status   = st;
        return r;
    endfunction

    assign rd_key  = i_rdata[KW+31:COUNT_W];
    assign rd_cnt  = i_rdata[COUNT_W-1:0];
    assign ptr_p1  = PW'(r_ptr) + PW'(1);
    assign ptr_p2  = PW'(r_ptr) + PW'(2);
    assign used_w  = PW'(r_used);
    assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_W'(1);
    assign cnt_dec = rd_cnt - COUNT_W'(1);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_key   = r_key;
        n_ptr   = r_ptr;
        n_used  = r_used;
        n_done  = 1'b0;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = r_ptr;
        o_wdata = {r_key, COUNT_W'(1)};
        o_re    = 1'b0;
        o_raddr = r_ptr;
        do_nf   = 1'b0;
        nf_op   = r_op;
        nf_key  = r_key;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_cmd.opcode;
                    n_key = KW'(i_cmd.key);
                    n_ptr = '0;
                    if (i_cmd.opcode == OP_READ) begin
                        if (CW'(i_cmd.index) < CW'(r_used)) begin
                            o_re    = 1'b1;
                            o_raddr = AW'(i_cmd.index);
                            n_state = S_RD_WAIT;
                        end else begin
                            n_done = 1'b1;
                            n_res  = mk_res(1'b0, '0, r_used, '0, ST_RANGE);
                        end
                    end else if (r_used == '0) begin
                        do_nf  = 1'b1;
                        nf_op  = i_cmd.opcode;
                        nf_key = KW'(i_cmd.key);
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                o_re    = 1'b1;
                o_raddr = r_ptr;
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (rd_key == r_key) begin
                    case (r_op)
                        OP_ADD: begin
                            o_we    = 1'b1;
                            o_wdata = {r_key, cnt_inc};
                            n_done  = 1'b1;
                            n_res   = mk_res(1'b1, cnt_inc, r_used, '0, ST_OK);
                            n_state = S_IDLE;
                        end
                        OP_REMOVE: begin
                            if (rd_cnt > COUNT_W'(1)) begin
                                o_we    = 1'b1;
                                o_wdata = {r_key, cnt_dec};
                                n_done  = 1'b1;
                                n_res   = mk_res(1'b1, cnt_dec, r_used, '0, ST_OK);
                                n_state = S_IDLE;
                            end else if (ptr_p1 < used_w) begin
                                // last copy: close the gap before shrinking
                                n_state = S_SH_RD;
                            end else begin
                                n_used  = r_used - UW'(1);
                                n_done  = 1'b1;
                                n_res   = mk_res(1'b1, '0, n_used, '0, ST_OK);
                                n_state = S_IDLE;
                            end
                        end
                        default: begin
                            n_done  = 1'b1;
                            n_res   = mk_res(1'b1, rd_cnt, r_used, '0, ST_OK);
                            n_state = S_IDLE;
                        end
                    endcase
                end else if (ptr_p1 < used_w) begin
                    n_ptr   = r_ptr + AW'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    do_nf = 1'b1;
                end
            end
            S_SH_RD: begin
                o_re    = 1'b1;
                o_raddr = AW'(ptr_p1);
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
                n_ptr   = r_ptr + AW'(1);
                if (ptr_p2 < used_w) begin
                    n_state = S_SH_RD;
                end else begin
                    n_used  = r_used - UW'(1);
                    n_done  = 1'b1;
                    n_res   = mk_res(1'b1, '0, n_used, '0, ST_OK);
                    n_state = S_IDLE;
                end
            end
            S_RD_WAIT: begin
                n_done  = 1'b1;
                n_res   = mk_res(1'b0, '0, r_used, KEY_W'(rd_key), ST_OK);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // key absent: append on add (full status when no room), otherwise report not found
        if (do_nf) begin
            n_done  = 1'b1;
            n_state = S_IDLE;
            if (nf_op == OP_ADD) begin
                if (r_used == UW'(ENTRIES)) begin
                    n_res = mk_res(1'b0, '0, r_used, '0, ST_FULL);
                end else begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_used);
                    o_wdata = {nf_key, COUNT_W'(1)};
                    n_used  = r_used + UW'(1);
                    n_res   = mk_res(1'b0, COUNT_W'(1), n_used, '0, ST_OK);
                end
            end else begin
                n_res = mk_res(1'b0, '0, r_used, '0, ST_NOTFOUND);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_key <= n_key;
        r_ptr <= n_ptr;
        r_res <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> rtl/core/counted_multiset_table.sv
// Counted multiset table: dense insertion-ordered keys with occurrence counts
// held in one RAM (cms_ram), sequenced by cms_ctrl. Uses cms_pkg.
//
// One command is accepted when start is high and busy is low; its single
// result beat appears on o_result for exactly one cycle with o_done high and
// cannot be stalled. The table lives in one RAM with one read and one write
// port; the read data is registered. A read by index issues the RAM read as
// the command is accepted and answers from the registered data; an index out
// of range is answered without a read. Add, remove and look up scan from
// entry 0, reading and then comparing each entry examined; a miss on an empty
// table is answered without a scan. Removing the last copy of a key shifts
// every later entry down one place, each moved entry read and then written.
// busy drops in the cycle the result is shown, so the next command can be
// taken at the edge that takes the result.
// No clearing pass is needed after reset; the table comes up empty.
module counted_multiset_table #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  cms_pkg::t_cms_in   i_cmd,
    output logic               busy,
    output logic               o_done,
    output cms_pkg::t_cms_out  o_result
);
    import cms_pkg::*;

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int AW = $clog2(ENTRIES);
    localparam int UW = $clog2(ENTRIES + 1);
    localparam int EW = KW + COUNT_W;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    cms_ctrl #(
        .ENTRIES (ENTRIES),
        .KW      (KW),
        .AW      (AW),
        .UW      (UW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (o_result),
        .o_we     (ram_we),
        .o_waddr  (ram_waddr),
        .o_wdata  (ram_wdata),
        .o_re     (ram_re),
        .o_raddr  (ram_raddr),
        .i_rdata  (ram_rdata)
    );

    cms_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

>>> rtl/core/cms_chk.sv
// Port-level checks for counted_multiset_table, bound to the top level.
// Uses cms_pkg.
module cms_chk #(
    parameter int ENTRIES = 64
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input cms_pkg::t_cms_out o_result
);
    import cms_pkg::*;

    // an accepted command either keeps the block busy or answers next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("accepted beat neither busy nor answered");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !busy)
        else $error("activity right after reset");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status != ST_OK |-> !o_result.found && o_result.count == '0
            && o_result.read_key == '0)
        else $error("error beat carries data");

    a_full_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == ST_FULL |-> o_result.distinct == DIST_W'(ENTRIES))
        else $error("full status with room left");

    a_read_key_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.read_key != '0 |-> !o_result.found && o_result.count == '0
            && o_result.status == ST_OK)
        else $error("read key on a non-read beat");

endmodule

bind counted_multiset_table cms_chk #(
    .ENTRIES (ENTRIES)
) u_cms_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
